### hdl/spo_pkg.sv
// Shared types and constants for the shuffled play-order unit.
`default_nettype none
package spo_pkg;

  localparam int unsigned MaxTracksDefault = 1024;
  localparam logic [31:0] RngDefault       = 32'h9E37_79B9;
  localparam int unsigned TrackW           = 10;

  typedef enum logic [2:0] {
    OpInit    = 3'd0,
    OpSetCnt  = 3'd1,
    OpNext    = 3'd2,
    OpPrev    = 3'd3,
    OpQuery   = 3'd4,
    OpGoto    = 3'd5,
    OpShuffle = 3'd6,
    OpSpare   = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] count;
    logic [15:0] track;
    logic        on;
  } spo_in_t;

  typedef struct packed {
    logic [TrackW-1:0] current_track;
    logic [TrackW-1:0] next_track;
    logic [TrackW-1:0] previous_track;
    logic              shuffle_on;
  } spo_out_t;

  typedef enum logic [4:0] {
    StIdle,
    StLin,
    StShufDraw,
    StShufMod,
    StShufRdI,
    StShufRdJ,
    StShufWrI,
    StShufWrJ,
    StCurRd,
    StCurWait,
    StFindRd,
    StFindChk,
    StFrontRd,
    StFrontWr,
    StOutRd0,
    StOutRd1,
    StOutRd2,
    StOutDone
  } state_e;

  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] x;
    x = v ^ (v << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage
`default_nettype wire

### hdl/spo_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module spo_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

### hdl/spo_modu.sv
// Bit-serial 32-bit by 17-bit remainder unit.
`default_nettype none
module spo_modu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [16:0] den_i,
  output logic             done_o,
  output logic [16:0]      rem_o
);
  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q;
  logic [17:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, num_q[31]};
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit per cycle, restoring
      num_d = {num_q[30:0], 1'b0};
      rem_d = (trial >= {1'b0, den_i}) ? 17'(trial - {1'b0, den_i}) : trial[16:0];
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= busy_q && !busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  // done is high the cycle after the last step, when rem_o is final
  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### hdl/shuffled_play_order_unit.sv
// Top level of the shuffled play-order unit.
`default_nettype none
// Play-order unit: keeps a permutation of up to MaxTracks track numbers in a
// single-port RAM. Raise start for one cycle while busy is low; exactly
// one result beat follows on res_o, marked by res_valid_o, and busy drops
// in that same cycle. The receiver cannot stall. Cost is set by the RAM port
// and the serial remainder unit: init and set count write the tracks one
// by one; goto reads and checks one entry at a time; a shuffle takes, for
// each swap, a draw, a remainder and four RAM accesses. The seed is taken
// at the next init.
module shuffled_play_order_unit
  import spo_pkg::*;
#(
  parameter int unsigned MaxTracks = MaxTracksDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire spo_in_t  cmd_i,
  output logic          busy,
  input  wire logic     cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  output spo_out_t      res_o,
  output logic          res_valid_o
);
  localparam int unsigned AW = (MaxTracks > 1) ? $clog2(MaxTracks) : 1;
  localparam int unsigned CW = $clog2(MaxTracks + 1);

  state_e          state_q, state_d;
  logic [31:0]     seed_q, gen_q, gen_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic            shuf_q, shuf_d;
  logic            on_q, on_d;
  logic [2:0]      op_q, op_d;
  logic [15:0]     trk_q, trk_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   j_q, j_d;
  logic [15:0]     cur_q, cur_d;
  logic [15:0]     vi_q, vi_d;
  logic [5:0]      wait_q, wait_d;
  spo_out_t        res_q, res_d;
  logic            rv_q, rv_d;

  logic            we;
  logic [AW-1:0]   addr;
  logic [15:0]     wdata;
  logic [15:0]     rdata;
  logic [TrackW-1:0] rd_tr;

  logic            mod_start;
  logic            mod_done;
  logic [16:0]     mod_rem;
  logic [CW-1:0]   clamp;
  logic [CW:0]     pn, pp;

  spo_ram #(.Width(16), .Depth(MaxTracks)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  spo_modu u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (gen_q),
    .den_i   (17'(idx_q) + 17'd1),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign rd_tr = rdata[TrackW-1:0];
  assign clamp = ({16'd0, cmd_i.count} > 32'(MaxTracks)) ? CW'(MaxTracks)
                                                       : CW'(cmd_i.count);
  assign busy  = (state_q != StIdle);

  // next-state and datapath
  always_comb begin
    state_d = state_q;
    gen_d = gen_q; count_d = count_q; pos_d = pos_q; shuf_d = shuf_q;
    on_d = on_q; op_d = op_q; trk_d = trk_q; idx_d = idx_q; j_d = j_q;
    cur_d = cur_q; vi_d = vi_q; wait_d = wait_q; res_d = res_q;
    rv_d = 1'b0;
    we = 1'b0; addr = '0; wdata = '0; mod_start = 1'b0;
    pn = (CW+1)'(pos_q) + (CW+1)'(1);
    pp = (pos_q == '0) ? {1'b0, count_q} - (CW+1)'(1)
                       : (CW+1)'(pos_q) - (CW+1)'(1);
    case (state_q)
      StIdle: begin
        if (start) begin
          op_d = cmd_i.operation; trk_d = cmd_i.track; on_d = cmd_i.on;
          idx_d = '0;
          state_d = StOutRd0;
          case (op_e'(cmd_i.operation))
            OpInit: begin
              gen_d = (seed_q != 32'd0) ? seed_q : RngDefault;
              count_d = clamp; pos_d = '0; shuf_d = 1'b0;
              state_d = StLin;
            end
            OpSetCnt: begin
              count_d = clamp; pos_d = '0;
              state_d = StLin;
            end
            OpNext: if (count_q != '0) begin
              pos_d = (pn == {1'b0, count_q}) ? '0 : AW'(pn);
            end
            OpPrev: if (count_q != '0) begin
              pos_d = AW'(pp);
            end
            OpGoto: state_d = StFindRd;
            OpShuffle: begin
              if (count_q != '0) state_d = StCurRd;
              else shuf_d = cmd_i.on;
            end
            default: ;
          endcase
        end
      end
      StLin: begin
        if (idx_q < count_q) begin
          we = 1'b1; addr = AW'(idx_q); wdata = 16'(idx_q);
          idx_d = idx_q + 1'b1;
        end else if ((op_q == OpSetCnt && shuf_q) || op_q == OpShuffle) begin
          if (op_q == OpShuffle && !on_q) begin
            pos_d = ({16'd0, cur_q} < 32'(count_q)) ? AW'(cur_q) : '0;
            shuf_d = 1'b0;
            state_d = StOutRd0;
          end else if (count_q < CW'(2)) begin
            state_d = (op_q == OpShuffle) ? StFrontRd : StOutRd0;
            idx_d = '0;
          end else begin
            idx_d = count_q - 1'b1;
            state_d = StShufDraw;
          end
        end else begin
          state_d = StOutRd0;
        end
      end
      StShufDraw: begin
        gen_d = xorshift(gen_q);
        state_d = StShufMod;
        wait_d = 6'd0;
      end
      StShufMod: begin
        if (wait_q == 6'd0) begin
          mod_start = 1'b1;
          wait_d = 6'd1;
        end
        if (mod_done) begin
          j_d = AW'(mod_rem);
          state_d = StShufRdI;
        end
      end
      StShufRdI: begin
        addr = AW'(idx_q); state_d = StShufRdJ;
      end
      StShufRdJ: begin
        addr = j_q; vi_d = rdata; state_d = StShufWrI;
      end
      StShufWrI: begin
        we = 1'b1; addr = AW'(idx_q); wdata = rdata; state_d = StShufWrJ;
      end
      StShufWrJ: begin
        we = 1'b1; addr = j_q; wdata = vi_q;
        // the front swap after a shuffle runs once with op_q set to query
        if (idx_q == CW'(1) || op_q == OpQuery) begin
          idx_d = '0;
          state_d = (op_q == OpShuffle) ? StFrontRd : StOutRd0;
        end else begin
          idx_d = idx_q - 1'b1;
          state_d = StShufDraw;
        end
      end
      StCurRd: begin
        addr = pos_q; state_d = StCurWait;
      end
      StCurWait: begin
        cur_d = rdata; idx_d = '0; state_d = StLin;
      end
      StFindRd: begin
        if (idx_q < count_q) begin
          addr = AW'(idx_q); state_d = StFindChk;
        end else begin
          state_d = StOutRd0;
        end
      end
      StFindChk: begin
        if (rdata == trk_q) begin
          pos_d = AW'(idx_q);
          state_d = StOutRd0;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = StFindRd;
        end
      end
      StFrontRd: begin
        // search for the old current track; entry 0 is read later for the swap
        if (idx_q < count_q) begin
          addr = AW'(idx_q); state_d = StFrontWr;
        end else begin
          pos_d = '0; shuf_d = 1'b1; state_d = StOutRd0;
        end
      end
      StFrontWr: begin
        if (rdata == cur_q) begin
          j_d = AW'(idx_q);
          idx_d = '0;
          state_d = StShufRdI;
          op_d = OpQuery;
          pos_d = '0; shuf_d = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1; state_d = StFrontRd;
        end
      end
      StOutRd0: begin
        addr = pos_q; state_d = StOutRd1;
      end
      StOutRd1: begin
        addr = (pn == {1'b0, count_q}) ? '0 : AW'(pn);
        res_d.current_track = (count_q == '0) ? '0 : rd_tr;
        state_d = StOutRd2;
      end
      StOutRd2: begin
        addr = AW'(pp);
        res_d.next_track = (count_q == '0) ? '0 : rd_tr;
        state_d = StOutDone;
      end
      StOutDone: begin
        res_d.previous_track = (count_q == '0) ? '0 : rd_tr;
        res_d.shuffle_on = shuf_q;
        rv_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      seed_q <= '0; gen_q <= RngDefault; count_q <= '0; pos_q <= '0;
      shuf_q <= 1'b0; rv_q <= 1'b0; wait_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) seed_q <= cfg_wdata_i;
      gen_q <= gen_d; count_q <= count_d; pos_q <= pos_d;
      shuf_q <= shuf_d; rv_q <= rv_d; wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    on_q <= on_d; op_q <= op_d; trk_q <= trk_d; idx_q <= idx_d; j_q <= j_d;
    cur_q <= cur_d; vi_q <= vi_d; res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = rv_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && count_q != '0) |-> ({1'b0, pos_q} < {1'b0, count_q}))
    else $error("position outside track count");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MaxTracks))
    else $error("track count above maximum");
  a_res_on_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == StOutDone))
    else $error("result beat without finishing step");
endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the shuffled play-order unit.
`timescale 1ns / 100ps
module tb_top;
  import spo_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  spo_in_t     cmd;
  logic        busy;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  spo_out_t    res_o;
  logic        res_valid_o;

  shuffled_play_order_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cmd_i      (cmd),
    .busy       (busy),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  // Shadow copy of the play-order state
  logic [9:0]  order_ref [1024];
  int unsigned n_tracks;
  int unsigned play_pos;
  logic        shuf_flag;
  logic [31:0] rng;
  logic [31:0] seed_reg;

  spo_in_t  cmd_q [$];
  spo_out_t track_q [$];
  int       n_sent, n_seen, n_bad, n_big;
  int       op_hits [8];
  bit       calm, hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rng_step();
    logic [31:0] x;
    x = rng;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng = x;
    return x;
  endfunction

  function automatic void fill_in_sequence();
    for (int unsigned i = 0; i < n_tracks; i++) order_ref[i] = i[9:0];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [9:0] t;
    t = order_ref[a];
    order_ref[a] = order_ref[b];
    order_ref[b] = t;
  endfunction

  function automatic void fisher_yates();
    int unsigned j;
    if (n_tracks < 2) return;
    for (int unsigned i = n_tracks - 1; i > 0; i--) begin
      j = rng_step() % (i + 1);
      swap_slots(i, j);
    end
  endfunction

  function automatic int unsigned clamp_tracks(logic [15:0] c);
    return (c > 1024) ? 1024 : int'(c);
  endfunction

  function automatic spo_out_t play_step(spo_in_t c);
    spo_out_t    r;
    int unsigned cur, p;
    op_e         op;
    op = op_e'(c.operation);
    case (op)
      OpInit: begin
        rng = (seed_reg != 0) ? seed_reg : RngDefault;
        n_tracks = clamp_tracks(c.count);
        play_pos = 0;
        shuf_flag = 1'b0;
        fill_in_sequence();
      end
      OpSetCnt: begin
        n_tracks = clamp_tracks(c.count);
        play_pos = 0;
        fill_in_sequence();
        if (shuf_flag) fisher_yates();
      end
      OpNext: if (n_tracks != 0) play_pos = (play_pos + 1) % n_tracks;
      OpPrev: if (n_tracks != 0) play_pos = (play_pos % n_tracks + n_tracks - 1) % n_tracks;
      OpGoto: begin
        for (int unsigned i = 0; i < n_tracks; i++) begin
          if (order_ref[i] == c.track) begin
            play_pos = i;
            break;
          end
        end
      end
      OpShuffle: begin
        if (n_tracks != 0) begin
          cur = order_ref[play_pos % n_tracks];
          fill_in_sequence();
          if (c.on) begin
            fisher_yates();
            for (int unsigned i = 0; i < n_tracks; i++) begin
              if (order_ref[i] == cur) begin
                swap_slots(0, i);
                break;
              end
            end
            play_pos = 0;
          end else begin
            play_pos = (cur < n_tracks) ? cur : 0;
          end
        end
        shuf_flag = c.on;
      end
      default: ;
    endcase
    r = '0;
    if (n_tracks != 0) begin
      p = play_pos % n_tracks;
      r.current_track  = order_ref[p];
      r.next_track     = order_ref[(p + 1) % n_tracks];
      r.previous_track = order_ref[(p + n_tracks - 1) % n_tracks];
    end
    r.shuffle_on = shuf_flag;
    return r;
  endfunction

  // Driver: start is held until the beat is taken
  always @(posedge clk_i) begin : drv
    logic took;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        track_q.push_back(play_step(cmd));
        op_hits[cmd.operation]++;
        n_sent++;
      end
      if (!start || took) begin
        if (cmd_q.size() != 0 && !hold && (calm || $urandom_range(99) >= 28)) begin
          start <= 1'b1;
          cmd   <= cmd_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, check each strobe
  always @(posedge clk_i) begin
    spo_out_t want;
    if (rst_ni && res_valid_o) begin
      n_seen++;
      if (track_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("ERROR: unexpected result beat %p", res_o);
      end else begin
        want = track_q.pop_front();
        if (res_o !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("ERROR: beat %0d cur %0d/%0d next %0d/%0d prev %0d/%0d shuf %0b/%0b",
                     n_seen, want.current_track, res_o.current_track,
                     want.next_track, res_o.next_track,
                     want.previous_track, res_o.previous_track,
                     want.shuffle_on, res_o.shuffle_on);
        end
      end
    end
  end

  function automatic spo_in_t mk(op_e op, logic [15:0] c, logic [15:0] t, logic o);
    spo_in_t x;
    x.operation = op;
    x.count     = c;
    x.track     = t;
    x.on        = o;
    return x;
  endfunction

  // Mostly small lists; rarely a count from the full 16-bit range, which mostly clamps
  function automatic logic [15:0] pick_count();
    if ($urandom_range(99) < 3) begin
      n_big++;
      return 16'($urandom_range(65535));
    end
    return 16'($urandom_range(40));
  endfunction

  function automatic spo_in_t rand_item();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 8)  return mk(OpInit, pick_count(), 16'($urandom), 1'($urandom));
    if (w < 18) return mk(OpSetCnt, pick_count(), 16'($urandom), 1'($urandom));
    if (w < 38) return mk(OpNext, 16'($urandom), 16'($urandom), 1'($urandom));
    if (w < 55) return mk(OpPrev, 16'($urandom), 16'($urandom), 1'($urandom));
    if (w < 62) return mk(OpQuery, 16'($urandom), 16'($urandom), 1'($urandom));
    if (w < 80) begin
      if ($urandom_range(3) == 0)
        return mk(OpGoto, 16'($urandom), 16'($urandom), 1'($urandom));
      return mk(OpGoto, 16'($urandom), 16'($urandom_range(42)), 1'($urandom));
    end
    if (w < 96) return mk(OpShuffle, 16'($urandom), 16'($urandom), 1'($urandom));
    return mk(OpSpare, 16'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  task automatic drain();
    @(negedge clk_i);
    while (cmd_q.size() != 0 || start || track_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    seed_reg     = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cmd         = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    seed_reg    = '0;
    n_tracks    = 0;
    play_pos    = 0;
    shuf_flag   = 1'b0;
    rng         = RngDefault;
    calm        = 1'b0;
    hold        = 1'b0;
    for (int i = 0; i < 1024; i++) order_ref[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni = 1'b1;

    write_seed(32'h0);
    // directed: empty list, wrap, absent track, clamp, shuffle on and off
    cmd_q.push_back(mk(OpQuery, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpNext, 16'hFFFF, 16'hFFFF, 1'b1));
    cmd_q.push_back(mk(OpPrev, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpGoto, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpShuffle, 16'h0, 16'h0, 1'b1));
    cmd_q.push_back(mk(OpSetCnt, 16'd1, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpShuffle, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpInit, 16'd5, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpPrev, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpNext, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpNext, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpGoto, 16'h0, 16'd4, 1'b0));
    cmd_q.push_back(mk(OpNext, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpGoto, 16'h0, 16'hFFFF, 1'b0));
    cmd_q.push_back(mk(OpShuffle, 16'h0, 16'h0, 1'b1));
    cmd_q.push_back(mk(OpNext, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpSetCnt, 16'd7, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpShuffle, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpSpare, 16'hFFFF, 16'hFFFF, 1'b1));
    cmd_q.push_back(mk(OpInit, 16'hFFFF, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpPrev, 16'h0, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpGoto, 16'h0, 16'd1023, 1'b0));
    cmd_q.push_back(mk(OpInit, 16'd1024, 16'h0, 1'b0));
    cmd_q.push_back(mk(OpShuffle, 16'h0, 16'h0, 1'b1));
    drain();

    // random phases, each starts from init with a new seed
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_seed(32'hFFFF_FFFF);
        1: write_seed(32'h0);
        default: write_seed($urandom);
      endcase
      calm = (ph == 2);
      cmd_q.push_back(mk(OpInit, 16'($urandom_range(2, 30)), 16'($urandom), 1'($urandom)));
      for (int k = 0; k < 29; k++) cmd_q.push_back(rand_item());
      if (ph == 1) begin
        // hold the sender until every result is back, then resume
        @(negedge clk_i);
        while (cmd_q.size() > 15) @(negedge clk_i);
        hold = 1'b1;
        while (start || track_q.size() != 0) @(negedge clk_i);
        hold = 1'b0;
      end
      drain();
    end

    $display("Sent %0d commands, %0d results; init %0d setcnt %0d next %0d prev %0d",
             n_sent, n_seen, op_hits[OpInit], op_hits[OpSetCnt], op_hits[OpNext],
             op_hits[OpPrev]);
    $display("query %0d goto %0d shuffle %0d spare %0d, %0d full-size counts",
             op_hits[OpQuery], op_hits[OpGoto], op_hits[OpShuffle], op_hits[OpSpare],
             n_big);
    if (n_bad == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d", n_bad);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
